### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Request and result layouts, opcodes, register indexes and the word
// geometry of the free bitmap.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Geometry of one bitmap word and of a block number.
  localparam int unsigned WordW     = 32;
  localparam int unsigned BitW      = 5;
  localparam int unsigned BlkW      = 12;
  localparam int unsigned CntW      = 13;
  localparam int unsigned WaddrW    = BlkW - BitW;
  localparam int unsigned FieldSpan = 4096;

  // Opcodes of a request.
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // Result status codes.
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;

  // Register indexes of the configuration port.
  localparam logic CfgFirstBlock = 1'b0;
  localparam logic CfgBlockCount = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [BlkW-1:0] block;
  } req_t;

  typedef struct packed {
    logic [BlkW-1:0] granted_block;
    logic            status;
  } res_t;

endpackage

### rtl/bba_mem.sv
// ----------------------------------------------------------------------------
// bba_mem: free bitmap storage
// One word-wide synchronous memory with one read and one write port and a
// registered read. A row never written since reset reads as all zero.
// ----------------------------------------------------------------------------
module bba_mem #(
  parameter int unsigned AddrW = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [bba_pkg::WordW-1:0]   wdata_i,
  output logic [bba_pkg::WordW-1:0]   rdata_o
);

  localparam int unsigned Depth = 1 << AddrW;

  logic [bba_pkg::WordW-1:0] mem_q [Depth];
  logic [bba_pkg::WordW-1:0] rdata_q;
  logic [Depth-1:0]          row_vld_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Per-row valid bits stand in for clearing the array after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        row_vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= row_vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule

### rtl/bba_find.sv
// ----------------------------------------------------------------------------
// bba_find: free bit search within one bitmap word
// Masks the word to the blocks inside the search range [lo, hi) and finds
// the lowest remaining set bit.
// ----------------------------------------------------------------------------
module bba_find (
  input  logic [bba_pkg::WordW-1:0]  word_i,
  input  logic [bba_pkg::WaddrW-1:0] waddr_i,
  input  logic [bba_pkg::CntW-1:0]   lo_i,
  input  logic [bba_pkg::CntW-1:0]   hi_i,
  output logic                       hit_o,
  output logic [bba_pkg::BitW-1:0]   idx_o
);

  logic [bba_pkg::CntW-1:0]  hi_m1;
  logic [bba_pkg::WordW-1:0] ones;
  logic [bba_pkg::WordW-1:0] mask_lo;
  logic [bba_pkg::WordW-1:0] mask_hi;
  logic [bba_pkg::WordW-1:0] cand;

  assign hi_m1 = hi_i - bba_pkg::CntW'(1);
  assign ones  = '1;

  always_comb begin
    mask_lo = ones;
    mask_hi = ones;
    if (waddr_i == lo_i[bba_pkg::BlkW-1:bba_pkg::BitW]) begin
      mask_lo = ones << lo_i[bba_pkg::BitW-1:0];
    end
    if (waddr_i == hi_m1[bba_pkg::BlkW-1:bba_pkg::BitW]) begin
      mask_hi = ones >> (bba_pkg::BitW'(bba_pkg::WordW - 1) - hi_m1[bba_pkg::BitW-1:0]);
    end
  end

  assign cand  = word_i & mask_lo & mask_hi;
  assign hit_o = |cand;

  // Lowest set bit wins.
  always_comb begin
    idx_o = '0;
    for (int i = bba_pkg::WordW - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx_o = bba_pkg::BitW'(i);
      end
    end
  end

endmodule

### rtl/bitmap_block_allocator_rotor.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_rotor: next-fit block allocator over a free bitmap
// Keeps a free bitmap in a word-wide memory, a free count and a rotor, and
// serves allocate and free requests one at a time.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Direction  Handshake
//  request   start, busy, req_i                    in         start & !busy
//  result    res_valid_o, res_o                    out        strobe, no stall
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i      in         write on cfg_we_i
//
// A free request passes through the write-back state StFreeWr to its result
// strobe, or is answered straight from StIdle when the block lies beyond the
// bitmap limit. An allocate request that finds the free count at zero is
// answered straight from StIdle, and one with an empty allocatable range from
// StPrep. Otherwise it runs StPrep, StStart and StScan, and StStart and StScan
// once more when the search wraps to first_block up to the rotor; the scan
// reads one 32-bit bitmap word per cycle through the memory's single read
// port. Reset is asynchronous and leaves every block in use; the memory needs
// no clearing pass. The receiver cannot stall: each result is shown for
// exactly one cycle.
//
module bitmap_block_allocator_rotor #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  bba_pkg::req_t             req_i,
  output logic                      res_valid_o,
  output bba_pkg::res_t             res_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bba_pkg::CntW-1:0]  cfg_wdata_i
);

  // Only blocks addressable by a 12-bit block number are ever stored.
  localparam int unsigned EffBlocks =
    (NUM_BLOCKS < bba_pkg::FieldSpan) ? NUM_BLOCKS : bba_pkg::FieldSpan;
  localparam int unsigned NumWords = (EffBlocks + bba_pkg::WordW - 1) / bba_pkg::WordW;
  localparam int unsigned MemAw    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam logic [bba_pkg::CntW-1:0] EffLimit = bba_pkg::CntW'(EffBlocks);

  typedef enum logic [2:0] {
    StIdle,
    StFreeWr,
    StPrep,
    StStart,
    StScan
  } state_e;

  state_e                        state_q;
  logic [bba_pkg::BlkW-1:0]      first_q;
  logic [bba_pkg::CntW-1:0]      count_q;
  logic [bba_pkg::CntW-1:0]      free_total_q;
  logic [bba_pkg::BlkW-1:0]      rotor_q;
  logic [bba_pkg::BlkW-1:0]      blk_q;
  logic [bba_pkg::CntW-1:0]      lo_q;
  logic [bba_pkg::CntW-1:0]      hi_q;
  logic                          pass_q;
  logic [bba_pkg::WaddrW-1:0]    rd_addr_q;
  logic [bba_pkg::WaddrW-1:0]    last_q;
  logic                          more_q;
  logic                          chk_vld_q;
  logic [bba_pkg::WaddrW-1:0]    chk_addr_q;
  logic                          res_valid_q;
  bba_pkg::res_t                 res_q;

  logic [bba_pkg::CntW-1:0]      limit;
  logic [bba_pkg::CntW-1:0]      hi_m1;
  logic                          rot_ok;
  logic [bba_pkg::BlkW-1:0]      rot_eff;
  logic [bba_pkg::CntW-1:0]      rot_inc;
  logic [bba_pkg::CntW-1:0]      rot_next;
  logic                          accept;
  logic                          hit;
  logic [bba_pkg::BitW-1:0]      hit_idx;
  logic [bba_pkg::BlkW-1:0]      hit_blk;

  logic                          mem_re;
  logic [bba_pkg::WaddrW-1:0]    mem_raddr;
  logic                          mem_we;
  logic [bba_pkg::WaddrW-1:0]    mem_waddr;
  logic [bba_pkg::WordW-1:0]     mem_wdata;
  logic [bba_pkg::WordW-1:0]     mem_rdata;

  // The bitmap limit is the smaller of block_count and the stored span.
  assign limit  = (count_q < EffLimit) ? count_q : EffLimit;
  assign hi_m1  = hi_q - bba_pkg::CntW'(1);
  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  // A rotor outside first_block..limit-1 restarts at first_block.
  assign rot_ok   = (first_q <= rotor_q) && ({1'b0, rotor_q} < limit);
  assign rot_eff  = rot_ok ? rotor_q : first_q;
  assign rot_inc  = {1'b0, rot_eff} + bba_pkg::CntW'(1);
  assign rot_next = {1'b0, rotor_q} + bba_pkg::CntW'(1);
  assign hit_blk  = {chk_addr_q, hit_idx};

  bba_mem #(
    .AddrW (MemAw)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (MemAw'(mem_raddr)),
    .we_i    (mem_we),
    .waddr_i (MemAw'(mem_waddr)),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  bba_find u_find (
    .word_i  (mem_rdata),
    .waddr_i (chk_addr_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  // Memory port control. A free reads its word on acceptance and writes it
  // back in the next cycle; a scan issues one read per cycle and clears the
  // found bit in the cycle its word comes back.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_addr_q;
    mem_we    = 1'b0;
    mem_waddr = chk_addr_q;
    mem_wdata = mem_rdata & ~(bba_pkg::WordW'(1) << hit_idx);
    unique case (state_q)
      StIdle: begin
        mem_raddr = req_i.block[bba_pkg::BlkW-1:bba_pkg::BitW];
        mem_re    = accept && (req_i.opcode == bba_pkg::OpFree)
                    && ({1'b0, req_i.block} < limit);
      end
      StFreeWr: begin
        mem_we    = 1'b1;
        mem_waddr = blk_q[bba_pkg::BlkW-1:bba_pkg::BitW];
        mem_wdata = mem_rdata | (bba_pkg::WordW'(1) << blk_q[bba_pkg::BitW-1:0]);
      end
      StScan: begin
        mem_re = more_q;
        mem_we = chk_vld_q && hit;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= bba_pkg::BlkW'(1);
      count_q <= bba_pkg::CntW'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bba_pkg::CfgFirstBlock: first_q <= cfg_wdata_i[bba_pkg::BlkW-1:0];
        bba_pkg::CfgBlockCount: count_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: state, scan bookkeeping and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      free_total_q <= '0;
      rotor_q      <= '0;
      blk_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      pass_q       <= 1'b0;
      rd_addr_q    <= '0;
      last_q       <= '0;
      more_q       <= 1'b0;
      chk_vld_q    <= 1'b0;
      chk_addr_q   <= '0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            blk_q <= req_i.block;
            if (req_i.opcode == bba_pkg::OpFree) begin
              if ({1'b0, req_i.block} < limit) begin
                res_valid_q <= 1'b0;
                state_q     <= StFreeWr;
              end else begin
                // A free beyond the limit is ignored but still answered.
                res_valid_q <= 1'b1;
                res_q       <= '0;
              end
            end else if (free_total_q == '0) begin
              res_valid_q <= 1'b1;
              res_q       <= '{granted_block: '0, status: bba_pkg::StatusFull};
            end else begin
              res_valid_q <= 1'b0;
              state_q     <= StPrep;
            end
          end else begin
            res_valid_q <= 1'b0;
          end
        end

        StFreeWr: begin
          if (free_total_q < limit) begin
            free_total_q <= free_total_q + bba_pkg::CntW'(1);
          end
          res_valid_q <= 1'b1;
          res_q       <= '0;
          state_q     <= StIdle;
        end

        StPrep: begin
          if ({1'b0, rot_eff} >= limit) begin
            // Empty allocatable range: nothing can be found.
            rotor_q     <= first_q;
            res_valid_q <= 1'b1;
            res_q       <= '{granted_block: '0, status: bba_pkg::StatusFull};
            state_q     <= StIdle;
          end else begin
            res_valid_q <= 1'b0;
            rotor_q     <= rot_eff;
            if (rot_inc < limit) begin
              lo_q   <= rot_inc;
              hi_q   <= limit;
              pass_q <= 1'b0;
            end else begin
              // Nothing above the rotor: go straight to the wrapped range.
              lo_q   <= {1'b0, first_q};
              hi_q   <= rot_inc;
              pass_q <= 1'b1;
            end
            state_q <= StStart;
          end
        end

        StStart: begin
          res_valid_q <= 1'b0;
          rd_addr_q   <= lo_q[bba_pkg::BlkW-1:bba_pkg::BitW];
          last_q      <= hi_m1[bba_pkg::BlkW-1:bba_pkg::BitW];
          more_q      <= 1'b1;
          chk_vld_q   <= 1'b0;
          state_q     <= StScan;
        end

        StScan: begin
          if (chk_vld_q && hit) begin
            rotor_q      <= hit_blk;
            free_total_q <= free_total_q - bba_pkg::CntW'(1);
            res_valid_q  <= 1'b1;
            res_q        <= '{granted_block: hit_blk, status: bba_pkg::StatusOk};
            state_q      <= StIdle;
          end else if (more_q) begin
            res_valid_q <= 1'b0;
            chk_vld_q   <= 1'b1;
            chk_addr_q  <= rd_addr_q;
            rd_addr_q   <= rd_addr_q + bba_pkg::WaddrW'(1);
            more_q      <= (rd_addr_q != last_q);
          end else if (!pass_q) begin
            // Wrap once: first_block up to and including the rotor.
            res_valid_q <= 1'b0;
            lo_q        <= {1'b0, first_q};
            hi_q        <= rot_next;
            pass_q      <= 1'b1;
            state_q     <= StStart;
          end else begin
            rotor_q     <= first_q;
            res_valid_q <= 1'b1;
            res_q       <= '{granted_block: '0, status: bba_pkg::StatusFull};
            state_q     <= StIdle;
          end
        end

        default: begin
          res_valid_q <= 1'b0;
          state_q     <= StIdle;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
